[rtl/core/fdaf_pkg.sv]
// ----------------------------------------------------------------------------
// fdaf_pkg
// Shared types and constants for the fixed decimal ascii formatter.
// ----------------------------------------------------------------------------
package fdaf_pkg;

  // width of the signed input value and of its magnitude
  localparam int VALUE_W = 21;
  localparam int MAG_W   = 21;

  // ascii codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // control bits that ride along the cell chain
  typedef struct packed {
    logic vld;
    logic neg;
  } cell_ctrl_t;

  // power of ten, evaluated at elaboration
  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage

[rtl/core/fdaf_dd_cell.sv]
// ----------------------------------------------------------------------------
// fdaf_dd_cell
// One shift-add-3 cell of the binary to bcd chain: corrects every bcd digit,
// then shifts the top magnitude bit into the bcd word.
// ----------------------------------------------------------------------------
module fdaf_dd_cell #(
  parameter int NDIG = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  fdaf_pkg::cell_ctrl_t        ctrl_in,
  input  logic [fdaf_pkg::MAG_W-1:0]  mag_in,
  input  logic [NDIG*4-1:0]           bcd_in,
  output fdaf_pkg::cell_ctrl_t        ctrl_out,
  output logic [fdaf_pkg::MAG_W-1:0]  mag_out,
  output logic [NDIG*4-1:0]           bcd_out
);
  import fdaf_pkg::*;

  cell_ctrl_t        ctrl_r;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  logic [NDIG*4-1:0] bcd_r, bcd_nxt, bcd_adj;

  // add 3 to every digit of five or more, then shift in one bit
  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      bcd_adj[4*k +: 4] = (bcd_in[4*k +: 4] >= 4'd5) ? bcd_in[4*k +: 4] + 4'd3
                                                     : bcd_in[4*k +: 4];
    end
    bcd_nxt = {bcd_adj[NDIG*4-2:0], mag_in[MAG_W-1]};
    mag_nxt = {mag_in[MAG_W-2:0], 1'b0};
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= ctrl_in;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  assign ctrl_out = ctrl_r;
  assign mag_out  = mag_r;
  assign bcd_out  = bcd_r;

endmodule

[rtl/core/fdaf_serializer.sv]
// ----------------------------------------------------------------------------
// fdaf_serializer
// Holds one converted value and sends its text one byte per cycle while out_ready is high,
// skipping the sign and leading integer zeros where they are not printed.
// ----------------------------------------------------------------------------
module fdaf_serializer #(
  parameter int INT_DIGITS  = 3,
  parameter int FRAC_DIGITS = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fdaf_pkg::cell_ctrl_t                ctrl_in,
  input  logic [(INT_DIGITS+FRAC_DIGITS)*4-1:0] bcd_in,
  output logic                                load_ok,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_text_byte,
  output logic                                out_last_byte
);
  import fdaf_pkg::*;

  localparam int NDIG  = INT_DIGITS + FRAC_DIGITS;
  localparam int SLOTS = NDIG + 2;
  localparam int PW    = $clog2(SLOTS);
  localparam logic [PW-1:0] P_LAST  = PW'(SLOTS - 1);
  localparam logic [PW-1:0] P_POINT = PW'(INT_DIGITS + 1);
  localparam logic [PW-1:0] P_UNITS = PW'(INT_DIGITS);

  logic              busy_r, busy_nxt;
  logic              neg_r, neg_nxt;
  logic [PW-1:0]     p_r, p_nxt;
  logic [PW-1:0]     lz_r, lz_nxt;
  logic [NDIG*4-1:0] bcd_r, bcd_nxt;
  logic              seen;
  logic              fire, last;
  logic [PW:0]       idx_w;
  logic [3:0]        digit;

  // leading zero count over the integer digits above the units digit
  always_comb begin
    lz_nxt = '0;
    seen   = 1'b0;
    for (int k = NDIG - 1; k > FRAC_DIGITS; k--) begin
      if (!seen && bcd_in[4*k +: 4] == 4'd0) begin
        lz_nxt = lz_nxt + PW'(1);
      end else begin
        seen = 1'b1;
      end
    end
  end

  assign last    = (p_r == P_LAST);
  assign fire    = busy_r && out_ready;
  assign load_ok = !busy_r || (out_ready && last);

  // digit select for the current slot
  always_comb begin
    if (p_r <= P_UNITS) begin
      idx_w = (PW+1)'(NDIG) - {1'b0, p_r};
    end else begin
      idx_w = (PW+1)'(NDIG + 1) - {1'b0, p_r};
    end
    digit = 4'd0;
    for (int k = 0; k < NDIG; k++) begin
      if (idx_w == (PW+1)'(k)) begin
        digit = bcd_r[4*k +: 4];
      end
    end
  end

  // byte for the current slot
  always_comb begin
    if (p_r == '0) begin
      out_text_byte = CHAR_MINUS;
    end else if (p_r == P_POINT) begin
      out_text_byte = CHAR_POINT;
    end else begin
      out_text_byte = CHAR_ZERO | {4'd0, digit};
    end
  end

  assign out_valid     = busy_r;
  assign out_last_byte = last;

  // slot sequencing and load of the next value
  always_comb begin
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    p_nxt    = p_r;
    bcd_nxt  = bcd_r;
    if (fire && !last) begin
      p_nxt = (p_r == '0) ? lz_r + PW'(1) : p_r + PW'(1);
    end
    if (load_ok) begin
      busy_nxt = ctrl_in.vld;
      neg_nxt  = ctrl_in.neg;
      bcd_nxt  = bcd_in;
      p_nxt    = ctrl_in.neg ? '0 : lz_nxt + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    p_r   <= p_nxt;
    bcd_r <= bcd_nxt;
    if (load_ok) begin
      lz_r <= lz_nxt;
    end
  end

  // slot index stays inside the frame while a run is out
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> p_r <= P_LAST)
    else $error("slot index out of frame");

  // a byte that is not the last one is followed by more of the same run
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !last) |=> busy_r)
    else $error("run ended without last byte");

  // the minus slot is only visited for a negative value
  a_minus_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && p_r == '0) |-> neg_r)
    else $error("minus sign on a positive value");

endmodule

[rtl/core/fixed_decimal_ascii_formatter.sv]
// ----------------------------------------------------------------------------
// fixed_decimal_ascii_formatter
// Prints a signed value in thousandths as ascii decimal text, one byte per
// output item, through a chain of shift-add-3 cells and a byte serializer.
// ----------------------------------------------------------------------------
// path: from input item to first byte through 21 cells plus the serializer
// throughput: one byte per cycle while out_ready is high; a value gives 5 to 8 bytes
//   (2 + FRAC_DIGITS up to 2 + INT_DIGITS + FRAC_DIGITS), set by the serializer
// the chain shifts only when the serializer loads: every cycle while it is idle,
//   once per value while it sends text, so a new input item waits for the last byte
// reset: synchronous active-low rst_n clears all valid bits; no memory to clear
module fixed_decimal_ascii_formatter #(
  parameter int INT_DIGITS  = 3,
  parameter int FRAC_DIGITS = 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [fdaf_pkg::VALUE_W-1:0] in_value_thousandths,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_text_byte,
  output logic                             out_last_byte
);
  import fdaf_pkg::*;

  localparam int          NDIG  = INT_DIGITS + FRAC_DIGITS;
  localparam logic [63:0] LIMIT = pow10(NDIG) - 64'd1;

  cell_ctrl_t        ctrl_c [MAG_W+1];
  logic [MAG_W-1:0]  mag_c  [MAG_W+1];
  logic [NDIG*4-1:0] bcd_c  [MAG_W+1];
  logic              advance;
  logic              neg;
  logic [MAG_W-1:0]  mag_raw;

  // sign, magnitude and saturation at the entry of the chain
  always_comb begin
    neg     = in_value_thousandths[VALUE_W-1];
    mag_raw = neg ? MAG_W'(~in_value_thousandths + 1'b1)
                  : MAG_W'(in_value_thousandths);
  end

  assign ctrl_c[0].vld = in_valid;
  assign ctrl_c[0].neg = neg;
  assign mag_c[0]      = ({{(64-MAG_W){1'b0}}, mag_raw} > LIMIT) ? LIMIT[MAG_W-1:0]
                                                                : mag_raw;
  assign bcd_c[0]      = '0;

  assign in_ready = advance;

  // binary to bcd cell chain, one magnitude bit per cell
  for (genvar g = 0; g < MAG_W; g++) begin : g_cell
    fdaf_dd_cell #(
      .NDIG (NDIG)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (advance),
      .ctrl_in  (ctrl_c[g]),
      .mag_in   (mag_c[g]),
      .bcd_in   (bcd_c[g]),
      .ctrl_out (ctrl_c[g+1]),
      .mag_out  (mag_c[g+1]),
      .bcd_out  (bcd_c[g+1])
    );
  end

  // text serializer
  fdaf_serializer #(
    .INT_DIGITS  (INT_DIGITS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl_in       (ctrl_c[MAG_W]),
    .bcd_in        (bcd_c[MAG_W]),
    .load_ok       (advance),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_byte (out_text_byte),
    .out_last_byte (out_last_byte)
  );

  // nothing leaves in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // a stalled output keeps the chain frozen
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("chain moved while output stalled");

  // every output byte is a digit, a point or a minus
  a_byte_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_text_byte == CHAR_MINUS || out_text_byte == CHAR_POINT ||
                   (out_text_byte >= CHAR_ZERO && out_text_byte <= 8'h39)))
    else $error("unexpected output character");

endmodule

[tb/fixed_decimal_ascii_formatter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_decimal_ascii_formatter_tb
// Feeds signed thousandths values into the formatter and checks every ascii
// byte and its last-byte mark against a predicted text run. Directed values
// cover zero, sign, leading-zero suppression and saturation; random values
// follow with bursty input, a patterned output stall and a long output hold.
// ----------------------------------------------------------------------------
module fixed_decimal_ascii_formatter_tb;
  import fdaf_pkg::*;

  localparam int INT_DIGITS   = 3;
  localparam int FRAC_DIGITS  = 3;
  localparam int MAX_MAG      = 999999;
  localparam int RANDOM_ITEMS = 420;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 200;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    bit                        drain_first;
  } value_item_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] in_value_thousandths;
  logic                      out_valid;
  logic                      out_ready;
  logic [7:0]                out_text_byte;
  logic                      out_last_byte;

  value_item_t value_queue[$];
  text_char_t  text_expected_q[$];
  int          error_count;
  int          values_accepted;

  fixed_decimal_ascii_formatter #(
    .INT_DIGITS (INT_DIGITS),
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_value_thousandths(in_value_thousandths),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_text_byte       (out_text_byte),
    .out_last_byte       (out_last_byte)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // predict the text run of one value and queue it
  function automatic void format_decimal_text(input logic signed [VALUE_W-1:0] v);
    int         val;
    int         mag;
    int         scale;
    int         digit;
    bit         seen_nonzero;
    text_char_t run[$];
    text_char_t c;
    val = int'(v);
    mag = (val < 0) ? -val : val;
    if (mag > MAX_MAG) mag = MAX_MAG;
    seen_nonzero = 1'b0;
    c.last = 1'b0;
    if (val < 0) begin
      c.ch = CHAR_MINUS;
      run.push_back(c);
    end
    scale = 1;
    for (int i = 1; i < INT_DIGITS + FRAC_DIGITS; i++) scale = scale * 10;
    for (int d = INT_DIGITS + FRAC_DIGITS - 1; d >= 0; d--) begin
      digit = (mag / scale) % 10;
      c.ch = CHAR_ZERO + 8'(digit);
      if (d > FRAC_DIGITS) begin
        // leading zeros above the units digit are dropped
        if (digit != 0) seen_nonzero = 1'b1;
        if (seen_nonzero) run.push_back(c);
      end else begin
        run.push_back(c);
        if (d == FRAC_DIGITS) begin
          c.ch = CHAR_POINT;
          run.push_back(c);
        end
      end
      scale = scale / 10;
    end
    run[run.size()-1].last = 1'b1;
    foreach (run[k]) text_expected_q.push_back(run[k]);
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    error_count++;
  endtask

  task automatic add_value(input int v, input bit drain_first);
    value_item_t it;
    it.value       = VALUE_W'(v);
    it.drain_first = drain_first;
    value_queue.push_back(it);
  endtask

  // random value: mostly in range with a random digit count, some raw patterns
  function automatic int random_value();
    int cls;
    int ndig;
    int lim;
    int mag;
    cls = $urandom_range(0, 19);
    if (cls == 0) begin
      // any 21-bit pattern, sign-extended
      mag = int'($urandom_range(0, (1 << VALUE_W) - 1));
      return (mag >= (1 << (VALUE_W - 1))) ? mag - (1 << VALUE_W) : mag;
    end
    if (cls == 1) begin
      mag = $urandom_range(MAX_MAG - 20, MAX_MAG + 20);
    end else begin
      ndig = $urandom_range(1, INT_DIGITS + FRAC_DIGITS);
      lim = 1;
      for (int i = 0; i < ndig; i++) lim = lim * 10;
      mag = $urandom_range(0, lim - 1);
    end
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // input driver: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        format_decimal_text(in_value_thousandths);
        values_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (value_queue.size() > 0 &&
                     !(value_queue[0].drain_first && text_expected_q.size() != 0)) begin
          in_valid             <= 1'b1;
          in_value_thousandths <= value_queue[0].value;
          void'(value_queue.pop_front());
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output stall: 16-bit ready patterns of varying density, plus one long hold
  logic [15:0] ready_pattern = 16'hFFFF;
  int          pattern_pos   = 0;
  int          hold_left     = 0;
  bit          hold_done     = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && values_accepted >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (pattern_pos == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            ready_pattern = 16'hFFFF;
          end
          1: begin
            ready_pattern = 16'($urandom);
          end
          2: begin
            ready_pattern = 16'($urandom) | 16'($urandom);
          end
          default: begin
            ready_pattern = 16'($urandom) & 16'($urandom);
          end
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ready_pattern[pattern_pos];
      end
      pattern_pos = (pattern_pos + 1) % 16;
    end
  end

  // byte checker
  text_char_t want_char;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (text_expected_q.size() == 0) begin
        report_mismatch("unexpected byte", out_text_byte, 0);
      end else begin
        want_char = text_expected_q.pop_front();
        if (out_text_byte !== want_char.ch)
          report_mismatch("text_byte", out_text_byte, want_char.ch);
        if (out_last_byte !== want_char.last)
          report_mismatch("last_byte", out_last_byte, want_char.last);
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_value_thousandths = '0;
    out_ready            = 1'b0;
    error_count          = 0;
    values_accepted      = 0;

    // zero, smallest steps and sign
    add_value(0, 1'b0);
    add_value(1, 1'b0);
    add_value(-1, 1'b0);
    add_value(5, 1'b0);
    add_value(-50, 1'b0);
    add_value(500, 1'b0);
    // leading-zero suppression around each integer digit
    add_value(999, 1'b0);
    add_value(1000, 1'b0);
    add_value(-1000, 1'b0);
    add_value(9999, 1'b0);
    add_value(10000, 1'b0);
    add_value(10001, 1'b0);
    add_value(99999, 1'b0);
    add_value(100000, 1'b0);
    add_value(100100, 1'b0);
    add_value(-123456, 1'b0);
    // range edges and saturation
    add_value(MAX_MAG, 1'b0);
    add_value(-MAX_MAG, 1'b0);
    add_value(MAX_MAG + 1, 1'b0);
    add_value(-MAX_MAG - 1, 1'b0);
    add_value((1 << (VALUE_W - 1)) - 1, 1'b0);
    add_value(-(1 << (VALUE_W - 1)), 1'b0);

    // random values; the sender waits for a full drain at a few points
    for (int n = 0; n < RANDOM_ITEMS; n++)
      add_value(random_value(), (n == 0) || (n == 150) || (n == 330));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (value_queue.size() != 0 || in_valid || text_expected_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && text_expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
